// ===== sv/adip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII decimal integer parser package
// Shared widths, character codes, status codes, types and the width range
// check used by the parser datapath and its checker.
// ----------------------------------------------------------------------------
package adip_pkg;

  // Field widths.
  localparam int unsigned CharW   = 8;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned CountW  = 6;
  localparam int unsigned StatusW = 3;
  localparam int unsigned VwW     = 2;

  // Width of the product acc * 10 + d before the overflow check.
  localparam int unsigned ProdW = ValueW + 4;

  // Saturation point of the character count.
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_VALUE_WIDTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SIGNED_MODE = 1'b1;
  localparam int unsigned CfgDataW = 2;

  // Configuration reset values.
  localparam logic [VwW-1:0] VwReset     = 2'd3;
  localparam logic           SignedReset = 1'b1;

  // Character codes.
  localparam logic [CharW-1:0] CH_NUL    = 8'h00;
  localparam logic [CharW-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CharW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CharW-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CharW-1:0] CH_ZERO   = 8'h30;
  localparam logic [CharW-1:0] CH_NINE   = 8'h39;
  localparam logic [CharW-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CharW-1:0] CH_RBRACE = 8'h7D;

  // Target widths.
  localparam logic [VwW-1:0] VW_8  = 2'd0;
  localparam logic [VwW-1:0] VW_16 = 2'd1;
  localparam logic [VwW-1:0] VW_32 = 2'd2;
  localparam logic [VwW-1:0] VW_64 = 2'd3;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_DIGITS = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_BAD_TERM  = 3'd4
  } status_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [VwW-1:0] value_width;
    logic           signed_mode;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] consumed;
    status_e           status;
  } result_t;

  // True for the characters that may legally end a number.
  function automatic logic is_terminator(logic [CharW-1:0] c);
    return (c == CH_NUL) || (c == CH_QUOTE) || (c == CH_COMMA) ||
           (c == CH_RBRACK) || (c == CH_RBRACE);
  endfunction

  // Checks a magnitude against the configured width and signedness.
  function automatic logic in_range(logic [ValueW-1:0] mag, logic neg,
                                    logic [VwW-1:0] vw, logic sm);
    logic [ValueW-1:0] lim_u;
    logic [ValueW-1:0] lim_p;
    logic              ok;
    case (vw)
      VW_8:    lim_u = 64'h0000_0000_0000_00FF;
      VW_16:   lim_u = 64'h0000_0000_0000_FFFF;
      VW_32:   lim_u = 64'h0000_0000_FFFF_FFFF;
      VW_64:   lim_u = 64'hFFFF_FFFF_FFFF_FFFF;
      default: lim_u = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    // Largest positive value of the signed range.
    lim_p = lim_u >> 1;
    if (!sm) begin
      ok = (mag <= lim_u);
    end else if (neg) begin
      ok = (mag <= lim_p + 64'd1);
    end else begin
      ok = (mag <= lim_p);
    end
    return ok;
  endfunction

endpackage

// ===== sv/adip_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII decimal integer parser step
// Holds the number being built and folds in one character per advance:
// sign, digit (acc * 10 + d with overflow detection) or terminator, which
// forms the result and clears the number state.
// ----------------------------------------------------------------------------
module adip_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic [adip_pkg::CharW-1:0]    character_i,
  input  adip_pkg::cfg_t                cfg_i,
  output logic                          emit_o,
  output adip_pkg::result_t             result_o
);
  import adip_pkg::*;

  logic [ValueW-1:0] acc_q, acc_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              seen_q, seen_d;
  logic              neg_q, neg_d;
  logic              ovf_q, ovf_d;

  logic              is_minus;
  logic              is_digit;
  logic [ProdW-1:0]  prod;
  logic [CountW-1:0] cnt_inc;

  // Classify the character against the current number state.
  assign is_minus = (character_i == CH_MINUS) && cfg_i.signed_mode &&
                    (cnt_q == '0) && !neg_q && !seen_q;
  assign is_digit = (character_i >= CH_ZERO) && (character_i <= CH_NINE);
  assign emit_o   = !is_minus && !is_digit;

  // acc * 10 + d as (acc << 3) + (acc << 1) + d; any carry into the top
  // four bits means the value no longer fits in 64 bits.
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                {{(ProdW - CharW){1'b0}}, character_i - CH_ZERO};

  assign cnt_inc = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;

  // Next number state.
  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    seen_d = seen_q;
    neg_d  = neg_q;
    ovf_d  = ovf_q;
    if (advance_i) begin
      if (is_minus) begin
        neg_d = 1'b1;
        cnt_d = cnt_inc;
      end else if (is_digit) begin
        if (!ovf_q) begin
          if (prod[ProdW-1:ValueW] != '0) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = prod[ValueW-1:0];
          end
        end
        seen_d = 1'b1;
        cnt_d  = cnt_inc;
      end else begin
        acc_d  = '0;
        cnt_d  = '0;
        seen_d = 1'b0;
        neg_d  = 1'b0;
        ovf_d  = 1'b0;
      end
    end
  end

  // Result for a terminating character, by status priority.
  always_comb begin
    result_o.value    = '0;
    result_o.consumed = cnt_q;
    if (!seen_q) begin
      result_o.status = ST_NO_DIGITS;
    end else if (ovf_q) begin
      result_o.status = ST_OVERFLOW;
    end else if (!is_terminator(character_i)) begin
      result_o.status = ST_BAD_TERM;
    end else if (!in_range(acc_q, neg_q, cfg_i.value_width, cfg_i.signed_mode)) begin
      result_o.status = ST_RANGE;
    end else begin
      result_o.status = ST_OK;
      result_o.value  = neg_q ? (~acc_q + 64'd1) : acc_q;
    end
  end

  // Number state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      seen_q <= 1'b0;
      neg_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      neg_q  <= neg_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ===== sv/ascii_decimal_integer_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII decimal integer parser
// Streams ASCII characters in, one per beat, and gives one result beat per
// number: value, characters consumed and status.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, sustained, with the output draining.
// Path: a terminating character's beat passes the input register, then the
// result register; a full, stalled result register holds it back.
// Reset: clears the number state and both pipeline valids; value_width
// resets to 64 bits and signed_mode to signed.
module ascii_decimal_integer_parser_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Character input channel.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [adip_pkg::CharW-1:0]       character_i,
  // Result output channel.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [adip_pkg::ValueW-1:0]      value_o,
  output logic [adip_pkg::CountW-1:0]      consumed_o,
  output logic [adip_pkg::StatusW-1:0]     status_o,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [adip_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [adip_pkg::CfgDataW-1:0]    cfg_data_i
);
  import adip_pkg::*;

  cfg_t              cfg_q;
  logic              in_valid_q;
  logic [CharW-1:0]  char_q;
  logic              out_valid_q;
  result_t           out_q;
  logic              advance;
  logic              emit;
  result_t           result;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.value_width <= VwReset;
      cfg_q.signed_mode <= SignedReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VALUE_WIDTH: cfg_q.value_width <= cfg_data_i[VwW-1:0];
        CFG_SIGNED_MODE: cfg_q.signed_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The held character moves on unless it ends a number and the result
  // register is still full and stalled.
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= character_i;
    end
  end

  adip_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .character_i (char_q),
    .cfg_i       (cfg_q),
    .emit_o      (emit),
    .result_o    (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_q.value;
  assign consumed_o  = out_q.consumed;
  assign status_o    = out_q.status;

endmodule

// ===== sv/adip_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII decimal integer parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module adip_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [adip_pkg::ValueW-1:0]      value_o,
  input logic [adip_pkg::CountW-1:0]      consumed_o,
  input logic [adip_pkg::StatusW-1:0]     status_o
);
  import adip_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(value_o) && $stable(consumed_o) && $stable(status_o))
    else $error("result payload changed while stalled");

  // Any failing status reports a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (value_o == '0))
    else $error("nonzero value with failing status");

  // Without digits only a sign can have been consumed.
  a_nodig_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NO_DIGITS) |-> (consumed_o <= 6'd1))
    else $error("no-digit result consumed more than a sign");

  // A good number of one character is a single digit.
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) && (consumed_o == 6'd1) |->
      (value_o < 64'd10))
    else $error("single-character number out of digit range");

endmodule

bind ascii_decimal_integer_parser_top adip_checker u_adip_checker (.*);
